[rtl/bls_pkg.sv]
// shared constants, codes and request types for the bounded lifo stack
`default_nettype none

package bls_pkg;

    localparam int Depth = 64;
    localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountWidth = $clog2(Depth + 1);
    localparam int WordWidth = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_DUMP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        logic                        we;
        logic                        re;
        logic [AddrWidth-1:0]        waddr;
        logic [AddrWidth-1:0]        raddr;
        logic signed [WordWidth-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic                        valid;
        status_t                     status;
        logic                        last;
        logic                        from_mem;
        logic signed [WordWidth-1:0] value;
    } pend_t;

endpackage

`default_nettype wire

[rtl/bls_ram.sv]
// entry memory: one write port, one read port, registered read data
`default_nettype none

module bls_ram
(
    input  wire logic                                 clk,
    input  wire bls_pkg::mem_req_t                    req,
    output logic signed [bls_pkg::WordWidth-1:0]      rdata
);

    logic signed [bls_pkg::WordWidth-1:0] mem [bls_pkg::Depth];
    logic signed [bls_pkg::WordWidth-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bls_core.sv]
// stack sequencer: entry count, dump walk, memory requests and pending result
`default_nettype none

module bls_core
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           operation,
    input  wire logic signed [bls_pkg::WordWidth-1:0] push_value,
    input  wire logic                                 out_free,
    output bls_pkg::mem_req_t                         mem_req,
    output bls_pkg::pend_t                            pend
);

    localparam int CW = bls_pkg::CountWidth;
    localparam int AW = bls_pkg::AddrWidth;

    logic [CW-1:0]  count_reg, count_next;
    logic           dump_active_reg, dump_active_next;
    logic [AW-1:0]  dump_ptr_reg, dump_ptr_next;
    bls_pkg::pend_t pend_reg, pend_next;

    logic          p_adv;
    logic          accept;
    logic          empty;
    logic          full;
    logic [CW-1:0] count_m1;

    assign p_adv    = !pend_reg.valid || out_free;
    assign in_ready = !dump_active_reg && p_adv;
    assign accept   = in_valid && in_ready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(bls_pkg::Depth));
    assign count_m1 = count_reg - CW'(1);

    always_comb
    begin
        count_next       = count_reg;
        dump_active_next = dump_active_reg;
        dump_ptr_next    = dump_ptr_reg;
        pend_next        = pend_reg;
        mem_req.we       = 1'b0;
        mem_req.re       = 1'b0;
        mem_req.waddr    = count_reg[AW-1:0];
        mem_req.raddr    = count_m1[AW-1:0];
        mem_req.wdata    = push_value;

        if (p_adv)
        begin
            pend_next.valid = 1'b0;
        end

        if (dump_active_reg && p_adv)
        begin
            mem_req.re         = 1'b1;
            mem_req.raddr      = dump_ptr_reg;
            pend_next.valid    = 1'b1;
            pend_next.status   = bls_pkg::ST_OK;
            pend_next.last     = (dump_ptr_reg == '0);
            pend_next.from_mem = 1'b1;
            pend_next.value    = '0;
            if (dump_ptr_reg == '0)
            begin
                dump_active_next = 1'b0;
            end
            else
            begin
                dump_ptr_next = dump_ptr_reg - AW'(1);
            end
        end
        else if (accept)
        begin
            pend_next.valid    = 1'b1;
            pend_next.status   = bls_pkg::ST_OK;
            pend_next.last     = 1'b1;
            pend_next.from_mem = 1'b0;
            pend_next.value    = '0;
            case (bls_pkg::op_t'(operation))
                bls_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        pend_next.status = bls_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_req.we      = 1'b1;
                        count_next      = count_reg + CW'(1);
                        pend_next.value = push_value;
                    end
                end
                bls_pkg::OP_POP:
                begin
                    if (empty)
                    begin
                        pend_next.status = bls_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_req.re         = 1'b1;
                        count_next         = count_m1;
                        pend_next.from_mem = 1'b1;
                    end
                end
                bls_pkg::OP_PEEK:
                begin
                    if (empty)
                    begin
                        pend_next.status = bls_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_req.re         = 1'b1;
                        pend_next.from_mem = 1'b1;
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        pend_next.status = bls_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        pend_next.valid  = 1'b0;
                        dump_active_next = 1'b1;
                        dump_ptr_next    = count_m1[AW-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            dump_active_reg <= 1'b0;
            dump_ptr_reg    <= '0;
            pend_reg        <= '0;
        end
        else
        begin
            count_reg       <= count_next;
            dump_active_reg <= dump_active_next;
            dump_ptr_reg    <= dump_ptr_next;
            pend_reg        <= pend_next;
        end
    end

    assign pend = pend_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(bls_pkg::Depth))
        else $error("entry count above depth");

    a_dump_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        dump_active_reg |-> ({1'b0, dump_ptr_reg} < {1'b0, count_reg}))
        else $error("dump pointer outside stored entries");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.valid && !out_free |=> pend_reg.valid && $stable(pend_reg)
            && !$past(mem_req.re))
        else $error("pending result changed or memory reread while stalled");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        dump_active_reg |=> $stable(count_reg))
        else $error("entry count changed during dump");

endmodule

`default_nettype wire

[rtl/bounded_lifo_stack_unit.sv]
// top level of the bounded lifo stack: sequencer, entry memory and result register
//
// Bounded stack of signed 32-bit words held in a single-port-read,
// single-port-write synchronous memory of bls_pkg::Depth entries. Push, pop
// and peek may follow back to back while results are taken; each result
// passes the memory's registered read or the pending result register and
// then the output register, and a receiver stall can hold it between them.
// A dump starts the walk when it is accepted and then makes one memory read
// per entry, top to bottom, with last_of_run on the bottom entry; new
// requests are held off for the whole walk and while the receiver
// stalls. Error and empty results carry a zero value. No clearing pass is
// needed after reset; the stack comes up empty.
`default_nettype none

module bounded_lifo_stack_unit
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           operation,
    input  wire logic signed [bls_pkg::WordWidth-1:0] push_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [1:0]                                status,
    output logic signed [bls_pkg::WordWidth-1:0]      result_value,
    output logic                                      last_of_run
);

    bls_pkg::mem_req_t                    mem_req;
    bls_pkg::pend_t                       pend;
    logic signed [bls_pkg::WordWidth-1:0] ram_rdata;
    logic                                 out_free;

    logic                                 out_valid_reg;
    logic [1:0]                           out_status_reg;
    logic signed [bls_pkg::WordWidth-1:0] out_value_reg;
    logic                                 out_last_reg;

    assign out_free = !out_valid_reg || out_ready;

    bls_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .push_value (push_value),
        .out_free   (out_free),
        .mem_req    (mem_req),
        .pend       (pend)
    );

    bls_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pend.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pend.valid)
        begin
            out_status_reg <= pend.status;
            out_value_reg  <= pend.from_mem ? ram_rdata : pend.value;
            out_last_reg   <= pend.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;
    assign last_of_run  = out_last_reg;

endmodule

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for the bounded lifo stack unit
module testbench;

    localparam int IdlePercent = 23;
    localparam int HoldCycles = 250;
    localparam int WatchdogLimit = 3000;
    localparam int RandomItems = 232;
    localparam int TailCycles = 20;

    typedef logic signed [bls_pkg::WordWidth-1:0] word_t;

    typedef struct packed {
        bls_pkg::status_t status;
        word_t            value;
        logic             last;
    } result_t;

    typedef struct packed {
        bls_pkg::op_t     op;
        word_t            value;
        logic             has_result;
        bls_pkg::status_t status;
        word_t            word;
    } directed_row_t;

    typedef enum logic [1:0] {
        RUN_GROW,
        RUN_SHRINK,
        RUN_MIX
    } run_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    word_t       push_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    word_t       result_value;
    logic        last_of_run;

    word_t       stack_words [bls_pkg::Depth];
    int          stack_depth = 0;
    result_t     pending_results [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    directed_row_t directed_rows [22] = '{
        '{bls_pkg::OP_POP,  '0,            1'b1, bls_pkg::ST_EMPTY, '0},
        '{bls_pkg::OP_PEEK, '0,            1'b1, bls_pkg::ST_EMPTY, '0},
        '{bls_pkg::OP_DUMP, '0,            1'b1, bls_pkg::ST_EMPTY, '0},
        '{bls_pkg::OP_PUSH, 32'sh7fffffff, 1'b1, bls_pkg::ST_OK,    32'sh7fffffff},
        '{bls_pkg::OP_PUSH, 32'sh80000000, 1'b1, bls_pkg::ST_OK,    32'sh80000000},
        '{bls_pkg::OP_PUSH, '0,            1'b1, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_PUSH, -32'sd1,       1'b1, bls_pkg::ST_OK,    -32'sd1},
        '{bls_pkg::OP_PEEK, 32'sh12345678, 1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_DUMP, -32'sd1,       1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b1, bls_pkg::ST_OK,    -32'sd1},
        '{bls_pkg::OP_PUSH, 32'sh55555555, 1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_PUSH, 32'shaaaaaaaa, 1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_PEEK, '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b1, bls_pkg::ST_EMPTY, '0},
        '{bls_pkg::OP_PUSH, 32'sd1,        1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_DUMP, '0,            1'b0, bls_pkg::ST_OK,    '0},
        '{bls_pkg::OP_POP,  '0,            1'b0, bls_pkg::ST_OK,    '0}
    };

    bounded_lifo_stack_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    task automatic apply_stack_op(input bls_pkg::op_t op, input word_t value);
        int i;
        case (op)
            bls_pkg::OP_PUSH:
            begin
                if (stack_depth == bls_pkg::Depth)
                    pending_results.push_back('{bls_pkg::ST_OVERFLOW, '0, 1'b1});
                else
                begin
                    stack_words[stack_depth] = value;
                    stack_depth++;
                    pending_results.push_back('{bls_pkg::ST_OK, value, 1'b1});
                end
            end
            bls_pkg::OP_POP:
            begin
                if (stack_depth == 0)
                    pending_results.push_back('{bls_pkg::ST_EMPTY, '0, 1'b1});
                else
                begin
                    stack_depth--;
                    pending_results.push_back('{bls_pkg::ST_OK, stack_words[stack_depth],
                                                1'b1});
                end
            end
            bls_pkg::OP_PEEK:
            begin
                if (stack_depth == 0)
                    pending_results.push_back('{bls_pkg::ST_EMPTY, '0, 1'b1});
                else
                    pending_results.push_back('{bls_pkg::ST_OK, stack_words[stack_depth - 1],
                                                1'b1});
            end
            default:
            begin
                if (stack_depth == 0)
                    pending_results.push_back('{bls_pkg::ST_EMPTY, '0, 1'b1});
                else
                    for (i = stack_depth; i > 0; i--)
                        pending_results.push_back('{bls_pkg::ST_OK, stack_words[i - 1],
                                                    i == 1});
            end
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_request(input bls_pkg::op_t op, input word_t value,
                                input bit has_result = 1'b0,
                                input bls_pkg::status_t want_status = bls_pkg::ST_OK,
                                input word_t want_value = '0);
        while (!calm && $urandom_range(99) < IdlePercent)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_stack_op(op, value);
        if (has_result)
            pending_results[pending_results.size() - 1] = '{want_status, want_value, 1'b1};
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic bls_pkg::op_t pick_op(input run_kind_t kind);
        int roll;
        roll = $urandom_range(99);
        case (kind)
            RUN_GROW:
                return (roll < 85) ? bls_pkg::OP_PUSH :
                       (roll < 95) ? bls_pkg::OP_PEEK : bls_pkg::OP_POP;
            RUN_SHRINK:
                return (roll < 80) ? bls_pkg::OP_POP :
                       (roll < 94) ? bls_pkg::OP_PEEK : bls_pkg::OP_DUMP;
            default:
                return (roll < 35) ? bls_pkg::OP_PUSH : (roll < 65) ? bls_pkg::OP_POP :
                       (roll < 92) ? bls_pkg::OP_PEEK : bls_pkg::OP_DUMP;
        endcase
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, result_value %0d, last_of_run %0b",
                       status, result_value, last_of_run);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, actual %0d", want.value, result_value);
                    error_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_ready <= 1'b0;
                repeat (HoldCycles - 1)
                    @(negedge clk);
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IdlePercent);
        end
    end

    initial
    begin
        int count;
        int burst;
        run_kind_t kind;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = bls_pkg::OP_PUSH;
        push_value = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].value,
                         directed_rows[i].has_result, directed_rows[i].status,
                         directed_rows[i].word);
        drain_results();

        // fill to the top against a stalled receiver, then overflow and dump
        hold_off = 1'b1;
        while (stack_depth < bls_pkg::Depth)
            send_request(bls_pkg::OP_PUSH, word_t'($urandom));
        send_request(bls_pkg::OP_PUSH, word_t'($urandom));
        send_request(bls_pkg::OP_DUMP, word_t'($urandom));
        drain_results();

        count = 0;
        while (count < RandomItems)
        begin
            kind = run_kind_t'($urandom_range(2));
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                calm = (count >= 120 && count < 190);
                send_request(pick_op(kind), word_t'($urandom));
                count++;
            end
            if ($urandom_range(9) == 0)
                drain_results();
        end
        calm = 1'b0;

        drain_results();
        repeat (TailCycles)
            @(negedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
